// ===== sv/pickle_token_parser_top_assert.svh =====
// Assertion macros used by the checker file of the pickle token parser.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef PICKLE_TOKEN_PARSER_TOP_ASSERT_SVH
`define PICKLE_TOKEN_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PTP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pickle token parser check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pickle token parser check failed");

`endif

// ===== sv/ptp_pkg.sv =====
// Shared types and constants of the pickle token parser.
// Used by the parser core, the result queue, the top level and the checker.
package ptp_pkg;

	// Token kinds as shown on token_kind.
	localparam logic [2:0] KIND_STR_START = 3'd0;
	localparam logic [2:0] KIND_STR_BYTE  = 3'd1;
	localparam logic [2:0] KIND_NUMBER    = 3'd2;
	localparam logic [2:0] KIND_STOP      = 3'd3;
	localparam logic [2:0] KIND_UNSUP     = 3'd4;
	localparam logic [2:0] KIND_NO_STOP   = 3'd5;

	// Pickle opcodes handled by the parser.
	localparam logic [7:0] OP_SHORT_BINSTRING = 8'h55; // 'U'
	localparam logic [7:0] OP_BINUNICODE      = 8'h58; // 'X'
	localparam logic [7:0] OP_BININT1         = 8'h4B; // 'K'
	localparam logic [7:0] OP_BININT2         = 8'h4D; // 'M'
	localparam logic [7:0] OP_BININT4         = 8'h4A; // 'J'
	localparam logic [7:0] OP_LONG1           = 8'h8A;
	localparam logic [7:0] OP_PROTO           = 8'h80;
	localparam logic [7:0] OP_BINPUT          = 8'h71; // 'q'
	localparam logic [7:0] OP_LONG_BINPUT     = 8'h72; // 'r'
	localparam logic [7:0] OP_STOP            = 8'h2E; // '.'
	localparam logic [7:0] OP_MARK            = 8'h28; // '('
	localparam logic [7:0] OP_EMPTY_LIST      = 8'h5D; // ']'
	localparam logic [7:0] OP_EMPTY_DICT      = 8'h7D; // '}'
	localparam logic [7:0] OP_APPEND          = 8'h61; // 'a'
	localparam logic [7:0] OP_SETITEMS        = 8'h75; // 'u'
	localparam logic [7:0] OP_TUPLE1          = 8'h85;
	localparam logic [7:0] OP_TUPLE2          = 8'h86;
	localparam logic [7:0] OP_TUPLE3          = 8'h87;

	// Result queue geometry.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// One result item.
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [7:0]  data;
		logic        last;
	} result_t;

	// Results produced by one input item, handed to the queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

// ===== sv/ptp_parser.sv =====
// Parser core of the pickle token parser: input register, opcode state and
// the step logic that turns one table byte into zero, one or two results.
// Depends on ptp_pkg.
module ptp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  logic             cfg_wen,
	input  logic [31:0]      cfg_wdata,
	input  logic             room,
	output ptp_pkg::push_t   push
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_STRLEN,
		MODE_STRBYTE,
		MODE_NUMBER,
		MODE_LONGLEN,
		MODE_SKIP
	} mode_t;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        fire;

	mode_t       mode_q, mode_d;
	logic [31:0] remain_q, remain_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  pos_q, pos_d;
	logic        halted_q, halted_d;
	logic [31:0] key_q;

	logic        p_valid;
	ptp_pkg::result_t p_res, e_res;
	logic        e_valid;
	logic [31:0] acc_new;
	logic [31:0] remain_dec;

	// The input register moves on whenever the queue has room for two results.
	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// The key register takes every write; writes belong where no item is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wen) begin
			key_q <= cfg_wdata;
		end
	end

	// Little-endian byte merge for the first four value bytes.
	always_comb begin
		acc_new = acc_q;
		if (!pos_q[2]) begin
			acc_new = acc_q | ({24'd0, byte_s1} << {pos_q[1:0], 3'b000});
		end
	end

	assign remain_dec = remain_q - 32'd1;

	// Step logic for one table byte.
	always_comb begin
		mode_d   = mode_q;
		remain_d = remain_q;
		acc_d    = acc_q;
		pos_d    = pos_q;
		halted_d = halted_q;
		p_valid  = 1'b0;
		p_res    = '0;
		if (!halted_q) begin
			unique case (mode_q)
				MODE_IDLE: begin
					unique case (byte_s1)
						ptp_pkg::OP_SHORT_BINSTRING: begin
							mode_d = MODE_STRLEN; remain_d = 32'd1; acc_d = '0; pos_d = '0;
						end
						ptp_pkg::OP_BINUNICODE: begin
							mode_d = MODE_STRLEN; remain_d = 32'd4; acc_d = '0; pos_d = '0;
						end
						ptp_pkg::OP_BININT1: begin
							mode_d = MODE_NUMBER; remain_d = 32'd1; acc_d = '0; pos_d = '0;
						end
						ptp_pkg::OP_BININT2: begin
							mode_d = MODE_NUMBER; remain_d = 32'd2; acc_d = '0; pos_d = '0;
						end
						ptp_pkg::OP_BININT4: begin
							mode_d = MODE_NUMBER; remain_d = 32'd4; acc_d = '0; pos_d = '0;
						end
						ptp_pkg::OP_LONG1: begin
							mode_d = MODE_LONGLEN;
						end
						ptp_pkg::OP_PROTO, ptp_pkg::OP_BINPUT: begin
							mode_d = MODE_SKIP; remain_d = 32'd1; acc_d = '0; pos_d = '0;
						end
						ptp_pkg::OP_LONG_BINPUT: begin
							mode_d = MODE_SKIP; remain_d = 32'd4; acc_d = '0; pos_d = '0;
						end
						ptp_pkg::OP_MARK, ptp_pkg::OP_EMPTY_LIST, ptp_pkg::OP_EMPTY_DICT,
						ptp_pkg::OP_APPEND, ptp_pkg::OP_SETITEMS, ptp_pkg::OP_TUPLE1,
						ptp_pkg::OP_TUPLE2, ptp_pkg::OP_TUPLE3: begin
							mode_d = MODE_IDLE;
						end
						ptp_pkg::OP_STOP: begin
							p_valid    = 1'b1;
							p_res.kind = ptp_pkg::KIND_STOP;
							halted_d   = 1'b1;
						end
						default: begin
							p_valid    = 1'b1;
							p_res.kind = ptp_pkg::KIND_UNSUP;
							p_res.data = byte_s1;
							halted_d   = 1'b1;
						end
					endcase
				end
				MODE_STRLEN, MODE_NUMBER: begin
					acc_d    = acc_new;
					pos_d    = pos_q[2] ? pos_q : pos_q + 3'd1;
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						p_valid = 1'b1;
						if (mode_q == MODE_STRLEN) begin
							p_res.kind  = ptp_pkg::KIND_STR_START;
							p_res.value = acc_new;
							if (acc_new == '0) begin
								mode_d = MODE_IDLE;
							end else begin
								mode_d   = MODE_STRBYTE;
								remain_d = acc_new;
							end
						end else begin
							p_res.kind  = ptp_pkg::KIND_NUMBER;
							p_res.value = acc_new ^ key_q;
							mode_d      = MODE_IDLE;
						end
					end
				end
				MODE_LONGLEN: begin
					if (byte_s1 == 8'd0) begin
						p_valid     = 1'b1;
						p_res.kind  = ptp_pkg::KIND_NUMBER;
						p_res.value = key_q;
						mode_d      = MODE_IDLE;
					end else begin
						mode_d   = MODE_NUMBER;
						remain_d = {24'd0, byte_s1};
						acc_d    = '0;
						pos_d    = '0;
					end
				end
				MODE_STRBYTE: begin
					p_valid    = 1'b1;
					p_res.kind = ptp_pkg::KIND_STR_BYTE;
					p_res.data = byte_s1;
					remain_d   = remain_dec;
					if (remain_dec == '0) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_SKIP: begin
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						mode_d = MODE_IDLE;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
				end
			endcase
		end

		// End of table: report a missing stop, then rearm.
		e_valid     = last_s1 && !halted_d;
		e_res       = '0;
		e_res.kind  = ptp_pkg::KIND_NO_STOP;
		e_res.last  = 1'b1;
		if (last_s1) begin
			mode_d   = MODE_IDLE;
			remain_d = '0;
			acc_d    = '0;
			pos_d    = '0;
			halted_d = 1'b0;
		end
	end

	// Pack the results of this item in order, marking the final one.
	always_comb begin
		push = '0;
		if (fire) begin
			if (p_valid) begin
				push.first      = p_res;
				push.first.last = !e_valid;
				push.second     = e_res;
				push.count      = e_valid ? 2'd2 : 2'd1;
			end else if (e_valid) begin
				push.first = e_res;
				push.count = 2'd1;
			end
		end
	end

	// Parser state advances once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			remain_q <= '0;
			acc_q    <= '0;
			pos_q    <= '0;
			halted_q <= 1'b0;
		end else if (fire) begin
			mode_q   <= mode_d;
			remain_q <= remain_d;
			acc_q    <= acc_d;
			pos_q    <= pos_d;
			halted_q <= halted_d;
		end
	end

endmodule

// ===== sv/ptp_result_fifo.sv =====
// Result queue of the pickle token parser: takes up to two results a cycle
// and hands them out one per handshake. Depends on ptp_pkg.
module ptp_result_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  ptp_pkg::push_t   push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_stall,
	output ptp_pkg::result_t head
);

	ptp_pkg::result_t            entry_q [ptp_pkg::QUEUE_DEPTH];
	logic [ptp_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [ptp_pkg::QUEUE_AW:0]   count_q;
	logic                         pop;

	// Room for a full pair of results, so a consumed byte never overflows.
	assign room      = count_q <= (ptp_pkg::QUEUE_AW + 1)'(ptp_pkg::QUEUE_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign head      = entry_q[rd_ptr_q];

	// Storage writes, payload only.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_q + ptp_pkg::QUEUE_AW'(1)] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ptp_pkg::QUEUE_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ptp_pkg::QUEUE_AW'(1);
			end
			count_q <= count_q + (ptp_pkg::QUEUE_AW + 1)'(push.count)
				- (ptp_pkg::QUEUE_AW + 1)'(pop);
		end
	end

endmodule

// ===== sv/pickle_token_parser_top.sv =====
// Pickle token parser: reads a decompressed protocol 2 pickle table one byte per item and
// emits string, number and status tokens. A byte is taken every cycle as long as the
// four-entry result queue has room for two more results. Each byte waits in the input
// register and is parsed as it leaves it; its results go into the result queue, which
// drives the output. A final byte without stop that also yields a token of its own
// pushes two results into the queue.
// The xor_key register must be written only while no item is in flight.
// Depends on ptp_pkg, ptp_parser and ptp_result_fifo.
module pickle_token_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_kind,
	output logic [31:0] token_value,
	output logic [7:0]  byte_out,
	output logic        last_result
);

	ptp_pkg::push_t   push;
	ptp_pkg::result_t head;
	logic             room;

	// Byte-level parser with its input register.
	ptp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.room      (room),
		.push      (push)
	);

	// Result queue feeding the output channel.
	ptp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign token_kind  = head.kind;
	assign token_value = head.value;
	assign byte_out    = head.data;
	assign last_result = head.last;

endmodule

// ===== sv/ptp_checker.sv =====
// Port-level checker for the pickle token parser and its bind to the top level.
// Depends on ptp_pkg and pickle_token_parser_top_assert.svh.
`include "pickle_token_parser_top_assert.svh"

module ptp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  token_kind,
	input logic [31:0] token_value,
	input logic [7:0]  byte_out,
	input logic        last_result
);

	logic        has_value;
	logic        has_byte;
	logic        closing_kind;
	logic [43:0] token_bits;

	// Kind classes and the whole result item as one vector.
	assign has_value    = token_kind == ptp_pkg::KIND_STR_START ||
		token_kind == ptp_pkg::KIND_NUMBER;
	assign has_byte     = token_kind == ptp_pkg::KIND_STR_BYTE ||
		token_kind == ptp_pkg::KIND_UNSUP;
	assign closing_kind = token_kind == ptp_pkg::KIND_STOP ||
		token_kind == ptp_pkg::KIND_UNSUP || token_kind == ptp_pkg::KIND_NO_STOP;
	assign token_bits   = {token_kind, token_value, byte_out, last_result};

	// Only string starts and numbers carry a value.
	`PTP_ASSERT_SAME(a_value_zero, out_valid && !has_value, token_value == 32'd0)

	// Only string bytes and unsupported opcodes carry a byte.
	`PTP_ASSERT_SAME(a_byte_zero, out_valid && !has_byte, byte_out == 8'd0)

	// Stop, unsupported opcode and missing stop always close their item.
	`PTP_ASSERT_SAME(a_final_kinds, out_valid && closing_kind, last_result)

	// A stalled result is held.
	`PTP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(token_bits))

endmodule

bind pickle_token_parser_top ptp_checker u_ptp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.token_kind  (token_kind),
	.token_value (token_value),
	.byte_out    (byte_out),
	.last_result (last_result)
);

// ===== tb/pickle_token_parser_top_test.sv =====
// Self-checking testbench for pickle_token_parser_top: feeds pickle tables byte by byte and
// predicts every token in-line, with random sender gaps and receiver stalls.
// Depends on ptp_pkg and the pickle_token_parser_top RTL.
`timescale 1ns / 100ps

module pickle_token_parser_top_test;

	localparam int RANDOM_ITEMS = 1500;
	localparam int RANDOM_PHASES = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int RUN_LIMIT_NS = 5_000_000;

	localparam logic [7:0] STRUCT_OPS [8] = '{ptp_pkg::OP_MARK, ptp_pkg::OP_EMPTY_LIST,
		ptp_pkg::OP_EMPTY_DICT, ptp_pkg::OP_APPEND, ptp_pkg::OP_SETITEMS,
		ptp_pkg::OP_TUPLE1, ptp_pkg::OP_TUPLE2, ptp_pkg::OP_TUPLE3};

	typedef enum logic [2:0] {
		PM_IDLE, PM_STRLEN, PM_STRBYTE, PM_NUMBER, PM_LONGLEN, PM_SKIP
	} parse_mode_t;

	typedef enum logic [1:0] {
		STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN
	} stall_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [31:0] cfg_wdata = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  token_kind;
	logic [31:0] token_value;
	logic [7:0]  byte_out;
	logic        last_result;

	// Parser state as predicted by the testbench.
	parse_mode_t mode = PM_IDLE;
	logic [31:0] remaining = 32'h0;
	logic [31:0] acc = 32'h0;
	logic [7:0]  pos = 8'h0;
	logic        halted = 1'b0;
	logic [31:0] key_model = 32'h0;

	ptp_pkg::result_t expected_tokens [$];
	logic [7:0]  table_bytes [$];
	int          sent_items = 0;
	int          error_count = 0;
	int          burst_left = 0;
	bit          sender_gapless = 1'b0;
	int          hold_requests = 0;

	pickle_token_parser_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_value (token_value),
		.byte_out    (byte_out),
		.last_result (last_result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("[pickle_token_parser_top] ERROR");
		$finish;
	end

	function automatic ptp_pkg::result_t make_token(input logic [2:0] kind,
			input logic [31:0] value, input logic [7:0] data);
		ptp_pkg::result_t t;
		t.kind = kind;
		t.value = value;
		t.data = data;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic void start_field(input parse_mode_t m, input logic [31:0] count);
		mode = m;
		remaining = count;
		acc = 32'h0;
		pos = 8'h0;
	endfunction

	// Advance the predicted parser by one table byte and queue the tokens it yields.
	function automatic void predict_tokens(input logic [7:0] b, input logic fin);
		ptp_pkg::result_t toks [2];
		int n;
		n = 0;
		if (!halted) begin
			case (mode)
				PM_IDLE: begin
					case (b)
						ptp_pkg::OP_SHORT_BINSTRING: start_field(PM_STRLEN, 32'd1);
						ptp_pkg::OP_BINUNICODE: start_field(PM_STRLEN, 32'd4);
						ptp_pkg::OP_BININT1: start_field(PM_NUMBER, 32'd1);
						ptp_pkg::OP_BININT2: start_field(PM_NUMBER, 32'd2);
						ptp_pkg::OP_BININT4: start_field(PM_NUMBER, 32'd4);
						ptp_pkg::OP_LONG1: mode = PM_LONGLEN;
						ptp_pkg::OP_PROTO, ptp_pkg::OP_BINPUT: start_field(PM_SKIP, 32'd1);
						ptp_pkg::OP_LONG_BINPUT: start_field(PM_SKIP, 32'd4);
						ptp_pkg::OP_MARK, ptp_pkg::OP_EMPTY_LIST, ptp_pkg::OP_EMPTY_DICT,
						ptp_pkg::OP_APPEND, ptp_pkg::OP_SETITEMS, ptp_pkg::OP_TUPLE1,
						ptp_pkg::OP_TUPLE2, ptp_pkg::OP_TUPLE3: begin
						end
						ptp_pkg::OP_STOP: begin
							toks[n] = make_token(ptp_pkg::KIND_STOP, 32'h0, 8'h00);
							n++;
							halted = 1'b1;
						end
						default: begin
							toks[n] = make_token(ptp_pkg::KIND_UNSUP, 32'h0, b);
							n++;
							halted = 1'b1;
						end
					endcase
				end
				PM_STRLEN, PM_NUMBER: begin
					// Little-endian gather; bytes past the fourth do not change the value.
					if (pos < 8'd4)
						acc = acc | ({24'h0, b} << (8 * pos));
					pos = pos + 8'd1;
					remaining = remaining - 32'd1;
					if (remaining == 32'h0) begin
						if (mode == PM_STRLEN) begin
							toks[n] = make_token(ptp_pkg::KIND_STR_START, acc, 8'h00);
							n++;
							if (acc == 32'h0) begin
								mode = PM_IDLE;
							end else begin
								mode = PM_STRBYTE;
								remaining = acc;
							end
						end else begin
							toks[n] = make_token(ptp_pkg::KIND_NUMBER, acc ^ key_model, 8'h00);
							n++;
							mode = PM_IDLE;
						end
					end
				end
				PM_LONGLEN: begin
					if (b == 8'h00) begin
						toks[n] = make_token(ptp_pkg::KIND_NUMBER, key_model, 8'h00);
						n++;
						mode = PM_IDLE;
					end else begin
						start_field(PM_NUMBER, {24'h0, b});
					end
				end
				PM_STRBYTE: begin
					toks[n] = make_token(ptp_pkg::KIND_STR_BYTE, 32'h0, b);
					n++;
					remaining = remaining - 32'd1;
					if (remaining == 32'h0)
						mode = PM_IDLE;
				end
				PM_SKIP: begin
					remaining = remaining - 32'd1;
					if (remaining == 32'h0)
						mode = PM_IDLE;
				end
				default: mode = PM_IDLE;
			endcase
		end

		// The final byte of a table rearms the parser; without a stop it also reports that.
		if (fin) begin
			if (!halted) begin
				toks[n] = make_token(ptp_pkg::KIND_NO_STOP, 32'h0, 8'h00);
				n++;
			end
			start_field(PM_IDLE, 32'h0);
			halted = 1'b0;
		end

		if (n > 0)
			toks[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_tokens.push_back(toks[i]);
	endfunction

	// Offer one item, at times idling between bursts, and predict it once it is taken.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = 1;
				2: gap = $urandom_range(2, 5);
				default: gap = $urandom_range(6, 20);
			endcase
			if (gap != 0 && !sender_gapless) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do
			@(posedge clk);
		while (in_stall);
		sent_items++;
		predict_tokens(b, fin);
	endtask

	task automatic send_table();
		for (int i = 0; i < table_bytes.size(); i++)
			send_byte(table_bytes[i], i == table_bytes.size() - 1);
	endtask

	// Wait until every predicted token has come out and the pipeline is empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_key(input logic [31:0] k);
		settle();
		cfg_wen <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_wen <= 1'b0;
		key_model = k;
	endtask

	function automatic void add_random_bytes(input int count);
		repeat (count) table_bytes.push_back(8'($urandom));
	endfunction

	// Append one well-formed token with random content.
	function automatic void add_token();
		int len;
		logic [31:0] word;
		case ($urandom_range(0, 11))
			0, 1: begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
				table_bytes.push_back(ptp_pkg::OP_SHORT_BINSTRING);
				table_bytes.push_back(8'(len));
				add_random_bytes(len);
			end
			2: begin
				len = $urandom_range(0, 10);
				word = 32'(len);
				table_bytes.push_back(ptp_pkg::OP_BINUNICODE);
				for (int i = 0; i < 4; i++)
					table_bytes.push_back(word[8 * i +: 8]);
				add_random_bytes(len);
			end
			3: begin
				table_bytes.push_back(ptp_pkg::OP_BININT1);
				add_random_bytes(1);
			end
			4: begin
				table_bytes.push_back(ptp_pkg::OP_BININT2);
				add_random_bytes(2);
			end
			5: begin
				table_bytes.push_back(ptp_pkg::OP_BININT4);
				add_random_bytes(4);
			end
			6: begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
				table_bytes.push_back(ptp_pkg::OP_LONG1);
				table_bytes.push_back(8'(len));
				add_random_bytes(len);
			end
			7: begin
				table_bytes.push_back(ptp_pkg::OP_PROTO);
				add_random_bytes(1);
			end
			8: begin
				table_bytes.push_back(ptp_pkg::OP_BINPUT);
				add_random_bytes(1);
			end
			9: begin
				table_bytes.push_back(ptp_pkg::OP_LONG_BINPUT);
				add_random_bytes(4);
			end
			default: table_bytes.push_back(STRUCT_OPS[$urandom_range(0, 7)]);
		endcase
	endfunction

	// Build a table of random tokens with a random way of ending.
	function automatic void build_table(input int tokens);
		int cut;
		logic [7:0] op;
		bit handled;
		table_bytes.delete();
		if ($urandom_range(0, 3) != 0) begin
			table_bytes.push_back(ptp_pkg::OP_PROTO);
			table_bytes.push_back(8'h02);
		end
		repeat (tokens) add_token();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				table_bytes.push_back(ptp_pkg::OP_STOP);
				add_random_bytes($urandom_range(0, 3));
			end
			6: begin
				do begin
					op = 8'($urandom);
					case (op)
						ptp_pkg::OP_SHORT_BINSTRING, ptp_pkg::OP_BINUNICODE,
						ptp_pkg::OP_BININT1, ptp_pkg::OP_BININT2, ptp_pkg::OP_BININT4,
						ptp_pkg::OP_LONG1, ptp_pkg::OP_PROTO, ptp_pkg::OP_BINPUT,
						ptp_pkg::OP_LONG_BINPUT, ptp_pkg::OP_STOP, ptp_pkg::OP_MARK,
						ptp_pkg::OP_EMPTY_LIST, ptp_pkg::OP_EMPTY_DICT, ptp_pkg::OP_APPEND,
						ptp_pkg::OP_SETITEMS, ptp_pkg::OP_TUPLE1, ptp_pkg::OP_TUPLE2,
						ptp_pkg::OP_TUPLE3: handled = 1'b1;
						default: handled = 1'b0;
					endcase
				end while (handled);
				table_bytes.push_back(op);
				add_random_bytes($urandom_range(0, 3));
			end
			7: begin
				// Table cut short at a random point, often inside a token.
				cut = $urandom_range(1, table_bytes.size());
				while (table_bytes.size() > cut)
					void'(table_bytes.pop_back());
			end
			8: begin
				// String with a huge length that the end of the table abandons.
				table_bytes.push_back(ptp_pkg::OP_BINUNICODE);
				add_random_bytes(4 + $urandom_range(0, 4));
			end
			default: begin
			end
		endcase
	endfunction

	// Receiver: changes its stall style now and then, and honors long hold-off requests.
	stall_style_t stall_style = STALL_NONE;
	int           style_left = 0;
	int           hold_left = 0;
	int           holds_seen = 0;
	logic [7:0]   stall_pattern = 8'h00;

	always @(posedge clk) begin
		if (holds_seen != hold_requests) begin
			holds_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 3));
			style_left = $urandom_range(16, 200);
			stall_pattern = 8'($urandom);
		end else begin
			style_left--;
		end
		stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= stall_pattern[0];
			endcase
		end
	end

	// Compare each token taken from the block with the oldest prediction.
	always @(posedge clk) begin
		ptp_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: kind %0d value %h byte %h", token_kind, token_value,
					byte_out);
				error_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
					error_count++;
				end
				if (token_value !== want.value) begin
					$error("token_value: expected %h, got %h", want.value, token_value);
					error_count++;
				end
				if (byte_out !== want.data) begin
					$error("byte_out: expected %h, got %h", want.data, byte_out);
					error_count++;
				end
				if (last_result !== want.last) begin
					$error("last_result: expected %0d, got %0d", want.last, last_result);
					error_count++;
				end
			end
		end
	end

	// Every structural opcode, short strings of length zero and one, a stop, then a byte
	// that arrives halted at the end of the table.
	task automatic test_structure_and_strings();
		set_key(32'h0);
		table_bytes = {ptp_pkg::OP_PROTO, 8'hFF, ptp_pkg::OP_MARK, ptp_pkg::OP_EMPTY_LIST,
			ptp_pkg::OP_EMPTY_DICT, ptp_pkg::OP_APPEND, ptp_pkg::OP_SETITEMS,
			ptp_pkg::OP_TUPLE1, ptp_pkg::OP_TUPLE2, ptp_pkg::OP_TUPLE3,
			ptp_pkg::OP_SHORT_BINSTRING, 8'h00, ptp_pkg::OP_SHORT_BINSTRING, 8'h01, 8'hA5,
			ptp_pkg::OP_BININT1, 8'hFF, ptp_pkg::OP_STOP, 8'h7F};
		send_table();
	endtask

	// Numbers under an all-ones key, LONG1 of length zero and of length six, the skips,
	// and an unsupported opcode.
	task automatic test_keyed_numbers();
		set_key(32'hFFFF_FFFF);
		table_bytes = {ptp_pkg::OP_BINUNICODE, 8'h01, 8'h00, 8'h00, 8'h00, 8'h5A,
			ptp_pkg::OP_BININT2, 8'h34, 8'h12, ptp_pkg::OP_BININT4, 8'h78, 8'h56, 8'h34,
			8'h80, ptp_pkg::OP_LONG1, 8'h00, ptp_pkg::OP_LONG1, 8'h06, 8'h01, 8'h02, 8'h03,
			8'h04, 8'h05, 8'h06, ptp_pkg::OP_BINPUT, 8'h00, ptp_pkg::OP_LONG_BINPUT, 8'h00,
			8'h01, 8'h02, 8'h03, 8'h8F, 8'h00};
		send_table();
	endtask

	// Tables that end early: inside a number, on the byte that completes a number,
	// inside a string, on an unsupported opcode, and while idle.
	task automatic test_early_end();
		set_key(32'h0000_FFFF);
		table_bytes = {ptp_pkg::OP_BININT2, 8'h01};
		send_table();
		table_bytes = {ptp_pkg::OP_BININT1, 8'h80};
		send_table();
		table_bytes = {ptp_pkg::OP_SHORT_BINSTRING, 8'h03, 8'h41};
		send_table();
		table_bytes = {8'h00};
		send_table();
		table_bytes = {ptp_pkg::OP_MARK};
		send_table();
	endtask

	// The receiver holds off for a long stretch while a long string keeps arriving.
	task automatic test_backpressure();
		set_key(32'($urandom));
		table_bytes = {ptp_pkg::OP_PROTO, 8'h02, ptp_pkg::OP_SHORT_BINSTRING, 8'hFF};
		add_random_bytes(255);
		table_bytes.push_back(ptp_pkg::OP_STOP);
		sender_gapless = 1'b1;
		hold_requests++;
		send_table();
		sender_gapless = 1'b0;
	endtask

	// Random tables under several keys, with some pure noise tables.
	task automatic test_random_tables();
		logic [31:0] keys [RANDOM_PHASES];
		int quota;
		keys = '{32'h0, 32'hFFFF_FFFF, 32'($urandom), 32'h8000_0001, 32'($urandom), 32'h0};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_key(keys[p]);
			quota = sent_items + RANDOM_ITEMS / RANDOM_PHASES;
			while (sent_items < quota) begin
				if ($urandom_range(0, 7) == 0) begin
					table_bytes.delete();
					add_random_bytes($urandom_range(1, 20));
				end else begin
					build_table($urandom_range(1, 12));
				end
				send_table();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_structure_and_strings();
		test_keyed_numbers();
		test_early_end();
		test_backpressure();
		test_random_tables();
		settle();
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[pickle_token_parser_top] OK");
		else
			$display("[pickle_token_parser_top] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ptp_pkg.sv
sv/ptp_parser.sv
sv/ptp_result_fifo.sv
sv/pickle_token_parser_top.sv
sv/ptp_checker.sv
tb/pickle_token_parser_top_test.sv
